// ===== hdl/rcg_pkg.sv =====
package rcg_pkg;

    localparam int QueueDepth = 4;
    localparam int MagW       = 48;
    localparam int RedW       = 24;
    localparam int SumW       = 50;
    localparam int LenW       = 25;
    localparam int NumW       = 39;
    localparam int RemW       = 40;
    localparam int QW         = 15;
    localparam int SqrtSteps  = 25;
    localparam int DivSteps   = 15;

    localparam logic [16:0]        HalfQ16 = 17'd65536;
    localparam logic signed [15:0] OneQ14  = 16'sd16384;

    typedef enum logic [3:0] {
        REG_EYE_X         = 4'd0,
        REG_EYE_Y         = 4'd1,
        REG_EYE_Z         = 4'd2,
        REG_RIGHT_BASIS   = 4'd3,
        REG_UP_BASIS      = 4'd4,
        REG_FORWARD_BASIS = 4'd5,
        REG_ASPECT_RATIO  = 4'd6,
        REG_FOCAL_LENGTH  = 4'd7
    } cfg_reg_t;

    typedef struct packed {
        logic [16:0] u;
        logic [16:0] v;
    } coord_t;

    typedef struct packed {
        logic signed [31:0] origin_x;
        logic signed [31:0] origin_y;
        logic signed [31:0] origin_z;
        logic signed [15:0] dir_x;
        logic signed [15:0] dir_y;
        logic signed [15:0] dir_z;
        logic               zero_length;
    } ray_t;

    typedef struct packed {
        logic [47:0] right_basis;
        logic [47:0] up_basis;
        logic [47:0] forward_basis;
        logic [15:0] aspect_ratio;
        logic [15:0] focal_length;
    } cam_cfg_t;

    typedef struct packed {
        logic                      zero;
        logic [2:0]                neg;
        logic [2:0][MagW-1:0]      mag;
    } vec_item_t;

    typedef struct packed {
        logic signed [15:0] dir_x;
        logic signed [15:0] dir_y;
        logic signed [15:0] dir_z;
        logic               zero_length;
    } dir_word_t;

    function automatic logic signed [15:0] basis_comp(input logic [47:0] pv,
                                                      input int unsigned k);
        logic signed [15:0] c;
        c = $signed(pv[16*k +: 16]);
        if (c > OneQ14)
            c = OneQ14;
        else if (c < -OneQ14)
            c = -OneQ14;
        return c;
    endfunction

endpackage

// ===== hdl/rcg_front.sv =====
module rcg_front
    import rcg_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      coord_valid,
    output logic      coord_stall,
    input  coord_t    coord,
    input  cam_cfg_t  cfg,
    output logic      push,
    output vec_item_t push_item,
    input  logic      full
);

    logic [3:0] vld_reg;
    logic       fen;

    logic signed [17:0] su_reg, sv_reg, su_next, sv_next;
    logic signed [34:0] pa_reg, pa_next;
    logic signed [32:0] pf2_reg [3];
    logic signed [32:0] pf2_next [3];
    logic signed [33:0] pu2_reg [3];
    logic signed [33:0] pu2_next [3];
    logic signed [32:0] pf3_reg [3];
    logic signed [33:0] pu3_reg [3];
    logic signed [50:0] pr3_reg [3];
    logic signed [50:0] pr3_next [3];
    logic signed [49:0] d_reg [3];
    logic signed [49:0] d_next [3];

    assign fen         = !vld_reg[3] || !full;
    assign coord_stall = !fen;
    assign push        = vld_reg[3] && !full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (fen)
        begin
            vld_reg <= {vld_reg[2:0], coord_valid};
        end
    end

    always_comb
    begin
        logic [16:0]        u_sat, v_sat;
        logic signed [18:0] su_wide, sv_wide;
        u_sat   = (coord.u > HalfQ16) ? HalfQ16 : coord.u;
        v_sat   = (coord.v > HalfQ16) ? HalfQ16 : coord.v;
        su_wide = $signed({1'b0, u_sat, 1'b0}) - $signed({2'b00, HalfQ16});
        sv_wide = $signed({2'b00, HalfQ16}) - $signed({1'b0, v_sat, 1'b0});
        su_next = su_wide[17:0];
        sv_next = sv_wide[17:0];
    end

    always_comb
    begin
        logic signed [50:0] dsum;
        pa_next = $signed({1'b0, cfg.aspect_ratio}) * su_reg;
        for (int k = 0; k < 3; k++)
        begin
            pf2_next[k] = $signed({1'b0, cfg.focal_length}) * basis_comp(cfg.forward_basis, k);
            pu2_next[k] = sv_reg * basis_comp(cfg.up_basis, k);
            pr3_next[k] = pa_reg * basis_comp(cfg.right_basis, k);
        end
        dsum = '0;
        for (int k = 0; k < 3; k++)
        begin
            dsum      = pr3_reg[k] + (51'(pf3_reg[k]) <<< 16) + (51'(pu3_reg[k]) <<< 12);
            d_next[k] = dsum[49:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (fen)
        begin
            su_reg <= su_next;
            sv_reg <= sv_next;
            pa_reg <= pa_next;
            for (int k = 0; k < 3; k++)
            begin
                pf2_reg[k] <= pf2_next[k];
                pu2_reg[k] <= pu2_next[k];
                pf3_reg[k] <= pf2_reg[k];
                pu3_reg[k] <= pu2_reg[k];
                pr3_reg[k] <= pr3_next[k];
                d_reg[k]   <= d_next[k];
            end
        end
    end

    always_comb
    begin
        logic signed [49:0] magw;
        magw = '0;
        push_item.zero = (d_reg[0] == '0) && (d_reg[1] == '0) && (d_reg[2] == '0);
        for (int k = 0; k < 3; k++)
        begin
            push_item.neg[k] = d_reg[k][49];
            magw             = d_reg[k][49] ? -d_reg[k] : d_reg[k];
            push_item.mag[k] = magw[MagW-1:0];
        end
    end

endmodule

// ===== hdl/rcg_queue.sv =====
module rcg_queue
    import rcg_pkg::*;
#(
    parameter int DEPTH = QueueDepth
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  vec_item_t push_item,
    output logic      full,
    input  logic      pop,
    output logic      nonempty,
    output vec_item_t head
);

    localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CntW = $clog2(DEPTH + 1);

    vec_item_t           mem [DEPTH];
    logic [PtrW-1:0]     wr_ptr_reg, rd_ptr_reg;
    logic [CntW-1:0]     count_reg;

    assign full     = (count_reg == CntW'(DEPTH));
    assign nonempty = (count_reg != '0);
    assign head     = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= (rd_ptr_reg == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            case ({push, pop})
                2'b10:   count_reg <= count_reg + 1'b1;
                2'b01:   count_reg <= count_reg - 1'b1;
                default: count_reg <= count_reg;
            endcase
        end
    end

endmodule

// ===== hdl/rcg_back.sv =====
module rcg_back
    import rcg_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      nonempty,
    input  vec_item_t head,
    output logic      pop,
    output logic      out_valid,
    input  logic      ray_stall,
    output dir_word_t dir
);

    localparam int Stages = 4 + SqrtSteps + 1 + DivSteps;
    localparam int RootW  = SumW + 1;

    typedef struct packed {
        logic                 zero;
        logic [2:0]           neg;
        logic [2:0][RedW-1:0] red;
    } lane_t;

    logic [Stages-1:0] vld_reg;
    logic              out_vld_reg;
    logic              ben;

    vec_item_t         item0_reg;
    logic [4:0]        s0_reg, s0_next;
    lane_t             lane1_reg, lane1_next, lane2_reg, lane3_reg, lane_d_reg;
    logic [2*RedW-1:0] sq2_reg [3];
    logic [SumW-1:0]   sum3_reg;

    logic [RootW-1:0]  sx_reg [SqrtSteps];
    logic [RootW-1:0]  sx_next [SqrtSteps];
    logic [RootW-1:0]  sr_reg [SqrtSteps];
    logic [RootW-1:0]  sr_next [SqrtSteps];
    lane_t             slane_reg [SqrtSteps];

    logic [NumW-1:0]   num_reg [3];
    logic [LenW-1:0]   len_d_reg;

    logic [RemW-1:0]   rem_reg [DivSteps][3];
    logic [RemW-1:0]   rem_next [DivSteps][3];
    logic [QW-1:0]     q_reg [DivSteps][3];
    logic [QW-1:0]     q_next [DivSteps][3];
    logic [LenW-1:0]   dlen_reg [DivSteps];
    lane_t             dlane_reg [DivSteps];

    dir_word_t         dir_reg, dir_next;

    assign ben       = !(out_vld_reg && ray_stall);
    assign pop       = nonempty && ben;
    assign out_valid = out_vld_reg;
    assign dir       = dir_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg     <= '0;
            out_vld_reg <= 1'b0;
        end
        else if (ben)
        begin
            vld_reg     <= {vld_reg[Stages-2:0], pop};
            out_vld_reg <= vld_reg[Stages-1];
        end
    end

    always_comb
    begin
        logic [MagW-1:0] orv;
        logic [5:0]      pos;
        logic [MagW-1:0] sh;
        orv = head.mag[0] | head.mag[1] | head.mag[2];
        pos = '0;
        for (int i = 0; i < MagW; i++)
        begin
            if (orv[i])
                pos = 6'(i);
        end
        s0_next = (pos > 6'(RedW - 1)) ? 5'(pos - 6'(RedW - 1)) : '0;
        lane1_next.zero = item0_reg.zero;
        lane1_next.neg  = item0_reg.neg;
        sh = '0;
        for (int k = 0; k < 3; k++)
        begin
            sh                = item0_reg.mag[k] >> s0_reg;
            lane1_next.red[k] = sh[RedW-1:0];
        end
    end

    always_comb
    begin
        logic [RootW-1:0] xin, rin, bitv, trial;
        for (int j = 0; j < SqrtSteps; j++)
        begin
            if (j == 0)
            begin
                xin = RootW'(sum3_reg);
                rin = '0;
            end
            else
            begin
                xin = sx_reg[j-1];
                rin = sr_reg[j-1];
            end
            bitv  = RootW'(1) << (2 * (SqrtSteps - 1 - j));
            trial = rin + bitv;
            if (xin >= trial)
            begin
                sx_next[j] = xin - trial;
                sr_next[j] = (rin >> 1) + bitv;
            end
            else
            begin
                sx_next[j] = xin;
                sr_next[j] = rin >> 1;
            end
        end
    end

    always_comb
    begin
        logic [RemW-1:0] rin, dv;
        logic [QW-1:0]   qin;
        logic [LenW-1:0] lin;
        for (int t = 0; t < DivSteps; t++)
        begin
            for (int k = 0; k < 3; k++)
            begin
                if (t == 0)
                begin
                    rin = RemW'(num_reg[k]);
                    qin = '0;
                    lin = len_d_reg;
                end
                else
                begin
                    rin = rem_reg[t-1][k];
                    qin = q_reg[t-1][k];
                    lin = dlen_reg[t-1];
                end
                dv = RemW'(lin) << (QW - 1 - t);
                if (rin >= dv)
                begin
                    rem_next[t][k] = rin - dv;
                    q_next[t][k]   = qin | (QW'(1) << (QW - 1 - t));
                end
                else
                begin
                    rem_next[t][k] = rin;
                    q_next[t][k]   = qin;
                end
            end
        end
    end

    always_comb
    begin
        logic [QW-1:0]      q;
        logic signed [15:0] qs;
        logic signed [15:0] dv3 [3];
        for (int k = 0; k < 3; k++)
        begin
            q      = q_reg[DivSteps-1][k];
            qs     = (q > QW'(OneQ14)) ? OneQ14 : $signed({1'b0, q});
            dv3[k] = dlane_reg[DivSteps-1].zero ? '0 :
                     (dlane_reg[DivSteps-1].neg[k] ? -qs : qs);
        end
        dir_next.dir_x       = dv3[0];
        dir_next.dir_y       = dv3[1];
        dir_next.dir_z       = dv3[2];
        dir_next.zero_length = dlane_reg[DivSteps-1].zero;
    end

    always_ff @(posedge clk)
    begin
        if (ben)
        begin
            item0_reg <= head;
            s0_reg    <= s0_next;
            lane1_reg <= lane1_next;
            lane2_reg <= lane1_reg;
            for (int k = 0; k < 3; k++)
                sq2_reg[k] <= lane1_reg.red[k] * lane1_reg.red[k];
            lane3_reg <= lane2_reg;
            sum3_reg  <= SumW'(sq2_reg[0]) + SumW'(sq2_reg[1]) + SumW'(sq2_reg[2]);
            for (int j = 0; j < SqrtSteps; j++)
            begin
                sx_reg[j]    <= sx_next[j];
                sr_reg[j]    <= sr_next[j];
                slane_reg[j] <= (j == 0) ? lane3_reg : slane_reg[j-1];
            end
            lane_d_reg <= slane_reg[SqrtSteps-1];
            len_d_reg  <= sr_reg[SqrtSteps-1][LenW-1:0];
            for (int k = 0; k < 3; k++)
                num_reg[k] <= {1'b0, slane_reg[SqrtSteps-1].red[k], 14'b0}
                              + NumW'(sr_reg[SqrtSteps-1][LenW-1:1]);
            for (int t = 0; t < DivSteps; t++)
            begin
                for (int k = 0; k < 3; k++)
                begin
                    rem_reg[t][k] <= rem_next[t][k];
                    q_reg[t][k]   <= q_next[t][k];
                end
                dlen_reg[t]  <= (t == 0) ? len_d_reg : dlen_reg[t-1];
                dlane_reg[t] <= (t == 0) ? lane_d_reg : dlane_reg[t-1];
            end
            dir_reg <= dir_next;
        end
    end

endmodule

// ===== hdl/pinhole_camera_ray_generator.sv =====
// Throughput: one word per cycle while neither coord_stall nor ray_stall holds the flow;
// the 25-step square root and 15-step divide are fully pipelined, and a 4-entry queue
// splits the vector front end from the normalizing back end.
// Reset: rst_n clears all valid state and loads the default camera (eye at the origin,
// right +x, up +y, forward -z, aspect ratio and focal length 1.0).
module pinhole_camera_ray_generator
    import rcg_pkg::*;
#(
    parameter int QUEUE_DEPTH = QueueDepth
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        coord_valid,
    output logic        coord_stall,
    input  coord_t      coord,
    output logic        ray_valid,
    input  logic        ray_stall,
    output ray_t        ray,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [3:0]  cfg_index,
    input  logic [47:0] cfg_data
);

    logic [31:0] eye_x_reg, eye_y_reg, eye_z_reg;
    logic [47:0] right_reg, up_reg, forward_reg;
    logic [15:0] aspect_reg, focal_reg;

    cam_cfg_t  cfg;
    logic      push, full, pop, nonempty;
    vec_item_t push_item, head;
    dir_word_t dir;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            eye_x_reg   <= '0;
            eye_y_reg   <= '0;
            eye_z_reg   <= '0;
            right_reg   <= 48'h0000_0000_4000;
            up_reg      <= 48'h0000_4000_0000;
            forward_reg <= 48'hC000_0000_0000;
            aspect_reg  <= 16'h1000;
            focal_reg   <= 16'h1000;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_EYE_X:         eye_x_reg   <= cfg_data[31:0];
                REG_EYE_Y:         eye_y_reg   <= cfg_data[31:0];
                REG_EYE_Z:         eye_z_reg   <= cfg_data[31:0];
                REG_RIGHT_BASIS:   right_reg   <= cfg_data;
                REG_UP_BASIS:      up_reg      <= cfg_data;
                REG_FORWARD_BASIS: forward_reg <= cfg_data;
                REG_ASPECT_RATIO:  aspect_reg  <= cfg_data[15:0];
                REG_FOCAL_LENGTH:  focal_reg   <= cfg_data[15:0];
                default:           ;
            endcase
        end
    end

    assign cfg.right_basis   = right_reg;
    assign cfg.up_basis      = up_reg;
    assign cfg.forward_basis = forward_reg;
    assign cfg.aspect_ratio  = aspect_reg;
    assign cfg.focal_length  = focal_reg;

    rcg_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .coord_valid (coord_valid),
        .coord_stall (coord_stall),
        .coord       (coord),
        .cfg         (cfg),
        .push        (push),
        .push_item   (push_item),
        .full        (full)
    );

    rcg_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .full      (full),
        .pop       (pop),
        .nonempty  (nonempty),
        .head      (head)
    );

    rcg_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .nonempty  (nonempty),
        .head      (head),
        .pop       (pop),
        .out_valid (ray_valid),
        .ray_stall (ray_stall),
        .dir       (dir)
    );

    assign ray.origin_x    = $signed(eye_x_reg);
    assign ray.origin_y    = $signed(eye_y_reg);
    assign ray.origin_z    = $signed(eye_z_reg);
    assign ray.dir_x       = dir.dir_x;
    assign ray.dir_y       = dir.dir_y;
    assign ray.dir_z       = dir.dir_z;
    assign ray.zero_length = dir.zero_length;

    assert property (@(posedge clk) disable iff (!rst_n)
        (ray_valid && ray.zero_length) |->
            (ray.dir_x == '0 && ray.dir_y == '0 && ray.dir_z == '0))
        else $error("zero-length ray carries a nonzero direction");

    assert property (@(posedge clk) disable iff (!rst_n)
        (ray_valid && !ray.zero_length) |->
            (ray.dir_x != '0 || ray.dir_y != '0 || ray.dir_z != '0))
        else $error("normalized ray lost its direction");

    assert property (@(posedge clk) disable iff (!rst_n)
        (full && !pop) |-> !push)
        else $error("word pushed into a full queue");

endmodule
